// File: src/tepq_pkg.sv
// Shared types and codes for the timed event priority queue.
// Operation and status codes, and the per-cycle command that drives the cell row.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tepq_pkg;
	localparam logic [1:0] OP_INSERT   = 2'd0;
	localparam logic [1:0] OP_PEEK     = 2'd1;
	localparam logic [1:0] OP_POP      = 2'd2;
	localparam logic [1:0] OP_EARLIEST = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam int GRAN_BITS = 16;

	typedef struct packed {
		logic ins;
		logic pop;
	} cell_cmd_t;
endpackage
`default_nettype wire

// File: src/timed_event_priority_queue_core.sv
// Timed event priority queue: a row of sorted cells plus a serial remainder unit.
// Depends on tepq_pkg, tepq_cell and tepq_rem.
//
// Usage:
//   s_tdata carries one request item: insert, peek, pop or earliest query.
//   m_tdata returns exactly one result item per request.
//   cfg_we/cfg_wdata write the granularity register (reset 1, zero acts as 1);
//   write it only while the block is idle.
// Sequencing:
//   Peek, pop and earliest go from acceptance straight to S_EXEC, which registers the result.
//   Insert goes through S_DIV, where the remainder unit resolves one bit of the
//   time per cycle, then S_RND, which rounds, then S_EXEC, where the cell row shifts.
//   One item is in work at a time; s_tready is high between items.
// Reset:
//   arst_n clears all cell valid bits, the count and the granularity to 1.
// Stall:
//   A result waits in the output register while m_tready is low; the next item
//   is still accepted and its work completes once the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module timed_event_priority_queue_core #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_BITS   = 48,
	parameter int DATA_BITS   = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// operation, event_time, event_data, maximum_time, maximum_given, zero fill
	input  wire logic [((2*TIME_BITS+DATA_BITS+3+7)/8)*8-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// found, result_time, result_data, pending_count, status, zero fill
	output logic [((TIME_BITS+DATA_BITS+$clog2(QUEUE_DEPTH+1)+3+7)/8)*8-1:0] m_tdata,
	input  wire logic cfg_we,
	input  wire logic [tepq_pkg::GRAN_BITS-1:0] cfg_wdata
);
	import tepq_pkg::*;

	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int IW  = 2*TIME_BITS + DATA_BITS + 3;
	localparam int OW  = TIME_BITS + DATA_BITS + CW + 3;
	localparam int OWP = ((OW + 7) / 8) * 8;
	localparam logic [TIME_BITS-1:0] TMASK = {TIME_BITS{1'b1}};

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_RND  = 2'd2;
	localparam logic [1:0] S_EXEC = 2'd3;

	logic [1:0]           state_q;
	logic [1:0]           op_q;
	logic [TIME_BITS-1:0] t_q, mt_q;
	logic [DATA_BITS-1:0] d_q;
	logic                 mg_q;
	logic [CW-1:0]        count_q;
	logic [GRAN_BITS-1:0] gran_q, g_eff;
	logic [OW-1:0]        out_q;
	logic                 ovalid_q;

	logic [1:0]           in_op;
	logic [TIME_BITS-1:0] in_t, in_mt;
	logic [DATA_BITS-1:0] in_d;
	logic                 in_mg;

	assign in_op = s_tdata[1:0];
	assign in_t  = s_tdata[2 +: TIME_BITS];
	assign in_d  = s_tdata[2+TIME_BITS +: DATA_BITS];
	assign in_mt = s_tdata[2+TIME_BITS+DATA_BITS +: TIME_BITS];
	assign in_mg = s_tdata[IW-1];

	assign g_eff = (gran_q == '0) ? GRAN_BITS'(1) : gran_q;

	logic                 accept, start, rem_busy, out_free, do_exec, full, empty;
	logic [GRAN_BITS-1:0] rem;
	logic [TIME_BITS-1:0] add, room, rounded;
	cell_cmd_t            cmd;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign start    = accept && (in_op == OP_INSERT);
	assign out_free = !ovalid_q || m_tready;
	assign do_exec  = (state_q == S_EXEC) && out_free;
	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);

	tepq_rem #(.TIME_BITS(TIME_BITS)) u_rem (
		.clk(clk), .arst_n(arst_n), .start(start), .dividend(in_t),
		.divisor(g_eff), .busy(rem_busy), .rem(rem)
	);

	always_comb begin
		add  = TIME_BITS'(g_eff) - TIME_BITS'(rem);
		room = (TMASK - 1'b1) - t_q;
		if (t_q == TMASK || rem == '0)
			rounded = t_q;
		else if (add > room)
			rounded = TMASK - 1'b1;
		else
			rounded = t_q + add;
	end

	assign cmd.ins = do_exec && (op_q == OP_INSERT) && !full;
	assign cmd.pop = do_exec && (op_q == OP_POP) && !empty;

	logic [QUEUE_DEPTH-1:0] cv, co;
	logic [TIME_BITS-1:0]   ct [QUEUE_DEPTH];
	logic [DATA_BITS-1:0]   cd [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                 lo, lv, rv;
		logic [TIME_BITS-1:0] lt, rt;
		logic [DATA_BITS-1:0] ld, rd;
		if (i == 0) begin : g_first
			assign lo = 1'b0;
			assign lv = 1'b0;
			assign lt = '0;
			assign ld = '0;
		end else begin : g_mid
			assign lo = co[i-1];
			assign lv = cv[i-1];
			assign lt = ct[i-1];
			assign ld = cd[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign rv = 1'b0;
			assign rt = '0;
			assign rd = '0;
		end else begin : g_inner
			assign rv = cv[i+1];
			assign rt = ct[i+1];
			assign rd = cd[i+1];
		end
		tepq_cell #(.TIME_BITS(TIME_BITS), .DATA_BITS(DATA_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .new_time(t_q), .new_data(d_q),
			.left_open(lo), .left_valid(lv), .left_time(lt), .left_data(ld),
			.right_valid(rv), .right_time(rt), .right_data(rd),
			.valid(cv[i]), .slot_time(ct[i]), .slot_data(cd[i]), .open(co[i])
		);
	end

	logic                 r_found;
	logic [TIME_BITS-1:0] r_time;
	logic [DATA_BITS-1:0] r_data;
	logic [CW-1:0]        r_count;
	logic [1:0]           r_status;

	always_comb begin
		r_found  = 1'b0;
		r_time   = TMASK;
		r_data   = '0;
		r_count  = count_q;
		r_status = ST_OK;
		case (op_q)
			OP_INSERT: begin
				r_time = t_q;
				if (full)
					r_status = ST_FULL;
				else
					r_count = count_q + 1'b1;
			end
			OP_PEEK, OP_POP: begin
				if (empty) begin
					r_status = ST_EMPTY;
				end else begin
					r_found = 1'b1;
					r_time  = ct[0];
					r_data  = cd[0];
					if (op_q == OP_POP)
						r_count = count_q - 1'b1;
				end
			end
			default: begin
				if (empty) begin
					r_status = ST_EMPTY;
					r_time   = mg_q ? mt_q : TMASK;
				end else begin
					r_time = ct[0];
					if (mg_q && ct[0] != TMASK && mt_q != TMASK && mt_q < ct[0])
						r_time = mt_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			gran_q   <= GRAN_BITS'(1);
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we)
				gran_q <= cfg_wdata;
			if (do_exec)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= (in_op == OP_INSERT) ? S_DIV : S_EXEC;
				end
				S_DIV: begin
					if (!rem_busy)
						state_q <= S_RND;
				end
				S_RND: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						count_q  <= r_count;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= in_op;
			t_q  <= in_t;
			d_q  <= in_d;
			mt_q <= in_mt;
			mg_q <= in_mg;
		end else if (state_q == S_RND) begin
			t_q <= rounded;
		end
		if (do_exec)
			out_q <= {r_status, r_count, r_data, r_time, r_found};
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {{(OWP-OW){1'b0}}, out_q};
endmodule
`default_nettype wire

// File: src/tepq_rem.sv
// Bit-serial remainder unit: dividend modulo a 16-bit divisor, one bit per cycle.
// Uses tepq_pkg for the divisor width.
`timescale 1ns / 1ps
`default_nettype none
module tepq_rem #(
	parameter int TIME_BITS = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [TIME_BITS-1:0]          dividend,
	input  wire logic [tepq_pkg::GRAN_BITS-1:0] divisor,
	output logic                               busy,
	output logic [tepq_pkg::GRAN_BITS-1:0]     rem
);
	import tepq_pkg::*;

	localparam int CNTW = $clog2(TIME_BITS + 1);

	logic [TIME_BITS-1:0] sh_q;
	logic [GRAN_BITS-1:0] r_q;
	logic [CNTW-1:0]      cnt_q;
	logic [GRAN_BITS:0]   trial;

	always_comb begin
		trial = {r_q, sh_q[TIME_BITS-1]};
		if (trial >= {1'b0, divisor})
			trial = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNTW'(TIME_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= dividend;
			r_q  <= '0;
		end else if (cnt_q != '0) begin
			sh_q <= {sh_q[TIME_BITS-2:0], 1'b0};
			r_q  <= trial[GRAN_BITS-1:0];
		end
	end

	assign busy = (cnt_q != '0);
	assign rem  = r_q;
endmodule
`default_nettype wire

// File: src/tepq_cell.sv
// One slot of the sorted event row: holds a time, a data handle and a valid bit.
// Shifts right on insert past the insertion point, left on pop. Uses tepq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tepq_cell #(
	parameter int TIME_BITS = 48,
	parameter int DATA_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tepq_pkg::cell_cmd_t  cmd,
	input  wire logic [TIME_BITS-1:0] new_time,
	input  wire logic [DATA_BITS-1:0] new_data,
	input  wire logic                 left_open,
	input  wire logic                 left_valid,
	input  wire logic [TIME_BITS-1:0] left_time,
	input  wire logic [DATA_BITS-1:0] left_data,
	input  wire logic                 right_valid,
	input  wire logic [TIME_BITS-1:0] right_time,
	input  wire logic [DATA_BITS-1:0] right_data,
	output logic                      valid,
	output logic [TIME_BITS-1:0]      slot_time,
	output logic [DATA_BITS-1:0]      slot_data,
	output logic                      open
);
	import tepq_pkg::*;

	logic                 valid_q;
	logic [TIME_BITS-1:0] time_q;
	logic [DATA_BITS-1:0] data_q;

	assign open = !valid_q || (time_q > new_time);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			if (left_open)
				valid_q <= left_valid;
			else if (open)
				valid_q <= 1'b1;
		end else if (cmd.pop) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_open) begin
				time_q <= left_time;
				data_q <= left_data;
			end else if (open) begin
				time_q <= new_time;
				data_q <= new_data;
			end
		end else if (cmd.pop) begin
			time_q <= right_time;
			data_q <= right_data;
		end
	end

	assign valid     = valid_q;
	assign slot_time = time_q;
	assign slot_data = data_q;
endmodule
`default_nettype wire

// File: src/tepq_check.sv
// Port-level checker for the timed event priority queue, bound to the top level.
// Depends on tepq_pkg for status codes.
`timescale 1ns / 1ps
`default_nettype none
module tepq_check #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_BITS   = 48,
	parameter int DATA_BITS   = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [((TIME_BITS+DATA_BITS+$clog2(QUEUE_DEPTH+1)+3+7)/8)*8-1:0] m_tdata
);
	import tepq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int CL = 1 + TIME_BITS + DATA_BITS;

	logic          found;
	logic [CW-1:0] cnt;
	logic [1:0]    st;

	assign found = m_tdata[0];
	assign cnt   = m_tdata[CL +: CW];
	assign st    = m_tdata[CL+CW +: 2];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt <= CW'(QUEUE_DEPTH))
		else $error("pending count beyond depth");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && found |-> st == ST_OK && cnt != '0 || st == ST_OK)
		else $error("found with non-ok status");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == ST_EMPTY |-> !found && cnt == '0)
		else $error("empty status with events pending");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == ST_FULL |-> cnt == CW'(QUEUE_DEPTH))
		else $error("drop reported below full");
endmodule

bind timed_event_priority_queue_core tepq_check #(
	.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS), .DATA_BITS(DATA_BITS)
) u_tepq_check (.*);
`default_nettype wire

// File: tb/sv/testbench.sv
// Testbench for timed_event_priority_queue_core: directed table then random stream traffic.
// Predicts each result with a sorted queue model and checks every result item field by field.
// Depends on tepq_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;
	import tepq_pkg::*;

	localparam int DEPTH = 64;
	localparam int TB = 48;
	localparam int DB = 32;
	localparam int SW = ((2*TB+DB+3+7)/8)*8;
	localparam int MW = ((TB+DB+7+3+7)/8)*8;
	localparam logic [47:0] TNONE = 48'hFFFF_FFFF_FFFF;
	localparam int WATCH_LIMIT = 20000;

	typedef struct packed {
		logic        found;
		logic [47:0] t;
		logic [31:0] d;
		logic [6:0]  cnt;
		logic [1:0]  st;
	} res_t;

	typedef struct {
		logic [1:0]  op;
		logic [47:0] et;
		logic [31:0] ed;
		logic [47:0] mt;
		logic        mg;
		logic        chk;
		res_t        r;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, m_tready = 0, cfg_we = 0;
	logic s_tready, m_tvalid;
	logic [SW-1:0] s_tdata = '0;
	logic [MW-1:0] m_tdata;
	logic [15:0] cfg_wdata = 16'd1;

	timed_event_priority_queue_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	logic [47:0] q_time [$];
	logic [31:0] q_data [$];
	logic [15:0] gran = 16'd1;
	res_t pending_results [$];
	int errors = 0;
	int idle_pct = 27;
	int watch = 0;

	function automatic logic [47:0] round_up(logic [47:0] t);
		logic [63:0] g, rem, add, room;
		g = (gran == 0) ? 64'd1 : 64'(gran);
		if (t == TNONE) return t;
		rem = 64'(t) % g;
		if (rem == 0) return t;
		add = g - rem;
		room = 64'(TNONE - 48'd1) - 64'(t);
		if (add > room) return TNONE - 48'd1;
		return t + add[47:0];
	endfunction

	function automatic res_t queue_step(logic [1:0] op, logic [47:0] et, logic [31:0] ed,
			logic [47:0] mt, logic mg);
		res_t r;
		logic [47:0] t;
		int pos;
		r = '0;
		case (op)
			OP_INSERT: begin
				t = round_up(et);
				r.t = t;
				if (q_time.size() >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					pos = q_time.size();
					while (pos > 0 && q_time[pos-1] > t) pos--;
					q_time.insert(pos, t);
					q_data.insert(pos, ed);
					r.st = ST_OK;
				end
			end
			OP_PEEK, OP_POP: begin
				if (q_time.size() == 0) begin
					r.t = TNONE;
					r.st = ST_EMPTY;
				end else begin
					r.found = 1;
					r.t = q_time[0];
					r.d = q_data[0];
					if (op == OP_POP) begin
						void'(q_time.pop_front());
						void'(q_data.pop_front());
					end
					r.st = ST_OK;
				end
			end
			default: begin
				if (q_time.size() == 0) begin
					r.t = mg ? mt : TNONE;
					r.st = ST_EMPTY;
				end else begin
					t = q_time[0];
					if (mg && t != TNONE && mt != TNONE && mt < t) t = mt;
					r.t = t;
					r.st = ST_OK;
				end
			end
		endcase
		r.cnt = 7'(q_time.size());
		return r;
	endfunction

	always @(posedge clk) begin
		res_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[48:1], m_tdata[80:49], m_tdata[87:81],
					m_tdata[89:88]};
				if (pending_results.size() == 0) begin
					$display("%0t unexpected result %h", $time, got);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (got.found !== want.found) begin
						$display("%0t found exp %h got %h", $time, want.found, got.found);
						errors++;
					end
					if (got.t !== want.t) begin
						$display("%0t time exp %h got %h", $time, want.t, got.t);
						errors++;
					end
					if (got.d !== want.d) begin
						$display("%0t data exp %h got %h", $time, want.d, got.d);
						errors++;
					end
					if (got.cnt !== want.cnt) begin
						$display("%0t count exp %0d got %0d", $time, want.cnt, got.cnt);
						errors++;
					end
					if (got.st !== want.st) begin
						$display("%0t status exp %0d got %0d", $time, want.st, got.st);
						errors++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= idle_pct);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) watch <= 0;
			else watch <= watch + 1;
			if (watch >= WATCH_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send(logic [1:0] op, logic [47:0] et, logic [31:0] ed, logic [47:0] mt,
			logic mg, logic chk, res_t fixed);
		res_t r;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		r = queue_step(op, et, ed, mt, mg);
		if (chk && r !== fixed) begin
			$display("%0t table exp %h model %h", $time, fixed, r);
			errors++;
		end
		pending_results.push_back(r);
		s_tdata <= SW'({mg, mt, ed, et, op});
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TB + 10) @(posedge clk);
	endtask

	task automatic set_gran(logic [15:0] g);
		drain();
		cfg_wdata <= g;
		cfg_we <= 1;
		@(posedge clk);
		cfg_we <= 0;
		gran = g;
	endtask

	function automatic logic [47:0] rand_time();
		case ($urandom_range(5))
			0: return TNONE;
			1: return TNONE - 48'($urandom_range(70000));
			2: return 48'($urandom_range(300));
			3: return 48'($urandom_range(5000));
			default: return {16'($urandom), 32'($urandom)};
		endcase
	endfunction

	row_t dir [] = '{
		'{OP_PEEK, 0, 0, 0, 0, 1, '{0, TNONE, 0, 0, ST_EMPTY}},
		'{OP_POP, 0, 0, 0, 0, 1, '{0, TNONE, 0, 0, ST_EMPTY}},
		'{OP_EARLIEST, 0, 0, 48'h123, 1, 1, '{0, 48'h123, 0, 0, ST_EMPTY}},
		'{OP_EARLIEST, 0, 0, 48'h123, 0, 1, '{0, TNONE, 0, 0, ST_EMPTY}},
		'{OP_INSERT, TNONE, 32'hFFFF_FFFF, 0, 0, 1, '{0, TNONE, 0, 1, ST_OK}},
		'{OP_INSERT, 0, 32'h1, 0, 0, 1, '{0, 0, 0, 2, ST_OK}},
		'{OP_INSERT, 5, 32'h2, 0, 0, 1, '{0, 5, 0, 3, ST_OK}},
		'{OP_INSERT, 5, 32'h3, 0, 0, 1, '{0, 5, 0, 4, ST_OK}},
		'{OP_INSERT, TNONE - 1, 32'h4, 0, 0, 1, '{0, TNONE - 1, 0, 5, ST_OK}},
		'{OP_EARLIEST, 0, 0, TNONE, 1, 1, '{0, 0, 0, 5, ST_OK}},
		'{OP_PEEK, 0, 0, 0, 0, 1, '{1, 0, 32'h1, 5, ST_OK}},
		'{OP_POP, 0, 0, 0, 0, 1, '{1, 0, 32'h1, 4, ST_OK}},
		'{OP_EARLIEST, 0, 0, 48'd2, 1, 1, '{0, 2, 0, 4, ST_OK}},
		'{OP_POP, 0, 0, 0, 0, 1, '{1, 5, 32'h2, 3, ST_OK}},
		'{OP_POP, 0, 0, 0, 0, 1, '{1, 5, 32'h3, 2, ST_OK}},
		'{OP_POP, 0, 0, 0, 0, 1, '{1, TNONE - 1, 32'h4, 1, ST_OK}},
		'{OP_EARLIEST, 0, 0, 48'd7, 1, 1, '{0, TNONE, 0, 1, ST_OK}},
		'{OP_POP, 0, 0, 0, 0, 1, '{1, TNONE, 32'hFFFF_FFFF, 0, ST_OK}}
	};

	initial begin
		int op;
		logic [15:0] gl [6] = '{16'd1, 16'hFFFF, 16'd0, 16'd7, 16'd1000, 16'd3};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir[i])
			send(dir[i].op, dir[i].et, dir[i].ed, dir[i].mt, dir[i].mg, dir[i].chk, dir[i].r);
		set_gran(16'hFFFF);
		send(OP_INSERT, TNONE - 2, 0, 0, 0, 1, '{0, TNONE - 1, 0, 1, ST_OK});
		send(OP_INSERT, 48'd1, 0, 0, 0, 1, '{0, 48'hFFFF, 0, 2, ST_OK});
		for (int k = 0; k < DEPTH; k++)
			send(OP_INSERT, rand_time(), $urandom, 0, 0, 0, '0);
		send(OP_POP, 0, 0, 0, 0, 0, '0);
		for (int ph = 0; ph < 6; ph++) begin
			set_gran(gl[ph]);
			idle_pct = (ph == 2) ? 0 : 27;
			for (int k = 0; k < 300; k++) begin
				op = $urandom_range(99);
				if (op < 45 + ((ph % 2) ? 20 : -20))
					send(OP_INSERT, rand_time(), $urandom, 0, 0, 0, '0);
				else
					send(2'($urandom_range(3) == 0 ? OP_PEEK : ($urandom_range(1) ?
						OP_POP : OP_EARLIEST)), rand_time(), $urandom, rand_time(),
						1'($urandom), 0, '0);
			end
		end
		drain();
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
